// ===== rtl/lppu_pkg.sv =====
// Shared types, constants and tables for the lidar point projection unit.
`default_nettype none
package lppu_pkg;

  localparam int ROT_FRAC     = 14;
  localparam int PIX_FRAC     = 4;
  localparam int MIN_DEPTH_MM = 1;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int TRIG_W       = 34;                 // Q2.30 with headroom
  localparam int ANG_W        = 33;                 // residual angle, 2^32 per turn
  localparam int PNT_W        = 26;                 // scan-plane point, Q.8 mm
  localparam int CAM_W        = 45;                 // camera coordinate
  localparam int NUM_W        = CAM_W + 17;         // numerator magnitude
  localparam int CNT_W        = $clog2(NUM_W);
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 48;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_START = TRIG_W'(34'sd652032874);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X       = 3'd0,
    REG_ROW_Y       = 3'd1,
    REG_ROW_Z       = 3'd2,
    REG_FOCAL       = 3'd3,
    REG_PRINCIPAL   = 3'd4,
    REG_SCAN_ANGLES = 3'd5,
    REG_IMAGE_SIZE  = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_INSIDE  = 2'd0,
    ST_INVALID = 2'd1,
    ST_BEHIND  = 2'd2,
    ST_OUTSIDE = 2'd3
  } status_t;

  typedef struct packed {
    logic              accept;
    logic              cordic_step;
    logic [STEP_W-1:0] step_idx;
    logic              point_mul;
    logic              cam_row_en;
    logic [1:0]        cam_row;
    logic              num_load;
    logic              div_step;
    logic              div_finish;
    logic              axis;
    logic              result_load;
  } lppu_cmd_t;

  typedef struct packed {
    logic range_ok;
    logic behind;
    logic out_free;
  } lppu_sts_t;

  function automatic logic signed [ANG_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
    logic signed [ANG_W-1:0] a;
    begin
      case (i)
        4'd0:    a = 33'sh020000000;
        4'd1:    a = 33'sh012E4051E;
        4'd2:    a = 33'sh009FB385B;
        4'd3:    a = 33'sh0051111D4;
        4'd4:    a = 33'sh0028B0D43;
        4'd5:    a = 33'sh00145D7E1;
        4'd6:    a = 33'sh000A2F61E;
        4'd7:    a = 33'sh000517C55;
        4'd8:    a = 33'sh00028BE53;
        4'd9:    a = 33'sh000145F2F;
        4'd10:   a = 33'sh0000A2F98;
        4'd11:   a = 33'sh0000517CC;
        4'd12:   a = 33'sh000028BE6;
        4'd13:   a = 33'sh0000145F3;
        4'd14:   a = 33'sh00000A2FA;
        default: a = 33'sh00000517D;
      endcase
      return a;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lppu_ctrl.sv =====
// Sequencer for the projection datapath: CORDIC, transform, two divisions, result.
`default_nettype none
module lppu_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  lppu_pkg::lppu_sts_t    sts,
  output lppu_pkg::lppu_cmd_t    cmd
);
  import lppu_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CORDIC = 9'b000000010,
    S_POINT  = 9'b000000100,
    S_CAM    = 9'b000001000,
    S_DEPTH  = 9'b000010000,
    S_NUM    = 9'b000100000,
    S_DIV    = 9'b001000000,
    S_FIN    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             axis, axis_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    axis_next  = axis;
    cmd        = '0;
    cmd.step_idx = cnt[STEP_W-1:0];
    cmd.cam_row  = cnt[1:0];
    cmd.axis     = axis;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          cnt_next   = '0;
          state_next = S_CORDIC;
        end
      end
      S_CORDIC: begin
        if (!sts.range_ok) begin
          state_next = S_DONE;
        end else begin
          cmd.cordic_step = 1'b1;
          cnt_next = cnt + 1'b1;
          if (cnt == CNT_W'(CORDIC_STEPS - 1)) state_next = S_POINT;
        end
      end
      S_POINT: begin
        cmd.point_mul = 1'b1;
        cnt_next      = '0;
        state_next    = S_CAM;
      end
      S_CAM: begin
        cmd.cam_row_en = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(2)) state_next = S_DEPTH;
      end
      S_DEPTH: begin
        axis_next  = 1'b0;
        state_next = sts.behind ? S_DONE : S_NUM;
      end
      S_NUM: begin
        cmd.num_load = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.div_finish = 1'b1;
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = S_NUM;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      axis  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      axis  <= axis_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lppu_datapath.sv =====
// Registers, CORDIC, camera transform, restoring divider and output register.
`default_nettype none
module lppu_datapath (
  input  wire                                clk,
  input  wire                                rst,
  input  lppu_pkg::lppu_cmd_t                cmd,
  output lppu_pkg::lppu_sts_t                sts,
  input  wire                                cfg_valid,
  input  wire  [lppu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [lppu_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire  [15:0]                        range_mm,
  input  wire                                range_valid,
  input  wire                                scan_start,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [1:0]                         status,
  output logic [11:0]                        pixel_x,
  output logic [11:0]                        pixel_y
);
  import lppu_pkg::*;

  logic [47:0] row [3];
  logic [31:0] focal, principal, scan_angles;
  logic [23:0] image_size;
  logic [15:0] beam_angle;

  logic [15:0]              rng;
  logic                     rvalid;
  logic                     flip;
  logic signed [TRIG_W-1:0] cx, cy;
  logic signed [ANG_W-1:0]  cz;
  logic signed [PNT_W-1:0]  px, py;
  logic signed [CAM_W-1:0]  cam [3];
  logic [NUM_W-1:0]         dvd;
  logic [CAM_W:0]           rem;
  logic                     neg;
  logic                     bad_x, bad_y;
  logic [11:0]              pix_x, pix_y;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row[0] <= '0; row[1] <= '0; row[2] <= '0;
      focal <= '0; principal <= '0; scan_angles <= '0; image_size <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW_X:       row[0]      <= cfg_data;
        REG_ROW_Y:       row[1]      <= cfg_data;
        REG_ROW_Z:       row[2]      <= cfg_data;
        REG_FOCAL:       focal       <= cfg_data[31:0];
        REG_PRINCIPAL:   principal   <= cfg_data[31:0];
        REG_SCAN_ANGLES: scan_angles <= cfg_data[31:0];
        REG_IMAGE_SIZE:  image_size  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // beam angle and CORDIC set-up
  logic [15:0] ang;
  logic [31:0] z0;
  logic        flip0;
  assign ang   = scan_start ? scan_angles[31:16] : beam_angle;
  assign z0    = {ang, 16'h0000};
  assign flip0 = z0[31] ^ z0[30];

  always_ff @(posedge clk) begin
    if (rst) beam_angle <= '0;
    else if (cmd.accept) beam_angle <= ang + scan_angles[15:0];
  end

  logic signed [TRIG_W-1:0] dx, dy, cval, sval;
  logic signed [ANG_W-1:0]  at;
  assign dx   = cy >>> cmd.step_idx;
  assign dy   = cx >>> cmd.step_idx;
  assign at   = atan_turn(cmd.step_idx);
  assign cval = flip ? -cx : cx;
  assign sval = flip ? -cy : cy;

  logic signed [TRIG_W+16:0] prod_c, prod_s;
  assign prod_c = $signed({1'b0, rng}) * cval;
  assign prod_s = $signed({1'b0, rng}) * sval;

  // camera row: rx*px + ry*py + t, with t scaled to the product format
  logic [47:0]             sel_row;
  logic signed [15:0]      rx, ry, tr;
  logic signed [CAM_W-1:0] cam_sum;
  assign sel_row = row[cmd.cam_row];
  assign rx = sel_row[47:32];
  assign ry = sel_row[31:16];
  assign tr = sel_row[15:0];
  assign cam_sum = rx * px + ry * py + (CAM_W'(tr) <<< (ROT_FRAC + 8));

  logic signed [CAM_W-1:0] num_src;
  logic [15:0]             f_sel, c_sel;
  logic signed [NUM_W-1:0] num;
  assign num_src = cmd.axis ? cam[1] : cam[0];
  assign f_sel   = cmd.axis ? focal[15:0] : focal[31:16];
  assign c_sel   = cmd.axis ? principal[15:0] : principal[31:16];
  assign num     = num_src * $signed({1'b0, f_sel});

  // one quotient bit per cycle
  logic [CAM_W:0] trial;
  logic           fits;
  assign trial = {rem[CAM_W-1:0], dvd[NUM_W-1]};
  assign fits  = trial >= {1'b0, cam[2]};

  // floor the quotient, add the centre, range-check against the image
  logic signed [NUM_W:0]   qs;
  logic signed [NUM_W+1:0] u;
  logic [11:0]             lim;
  logic                    bad;
  assign qs  = neg ? -($signed({1'b0, dvd}) + $signed({{NUM_W{1'b0}}, (rem != '0)}))
                   :  $signed({1'b0, dvd});
  assign u   = (NUM_W+2)'(qs) + $signed({{(NUM_W-14){1'b0}}, c_sel});
  assign lim = cmd.axis ? image_size[11:0] : image_size[23:12];
  assign bad = u[NUM_W+1] || (|u[NUM_W:PIX_FRAC+12])
            || (u[PIX_FRAC+11:PIX_FRAC] >= lim);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rng    <= range_mm;
      rvalid <= range_valid;
      flip   <= flip0;
      cx     <= CORDIC_GAIN_START;
      cy     <= '0;
      // after the half-turn fold the sign bit equals bit 30
      cz     <= $signed({z0[30], z0[30], z0[30:0]});
    end
    if (cmd.cordic_step) begin
      if (!cz[ANG_W-1]) begin
        cx <= cx - dx; cy <= cy + dy; cz <= cz - at;
      end else begin
        cx <= cx + dx; cy <= cy - dy; cz <= cz + at;
      end
    end
    if (cmd.point_mul) begin
      px <= prod_c[PNT_W+21:22];
      py <= prod_s[PNT_W+21:22];
    end
    if (cmd.cam_row_en) cam[cmd.cam_row] <= cam_sum;
    if (cmd.num_load) begin
      neg <= num[NUM_W-1];
      dvd <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      rem <= '0;
    end
    if (cmd.div_step) begin
      rem <= fits ? (trial - {1'b0, cam[2]}) : trial;
      dvd <= {dvd[NUM_W-2:0], fits};
    end
    if (cmd.div_finish) begin
      if (cmd.axis) begin
        bad_y <= bad; pix_y <= u[PIX_FRAC+11:PIX_FRAC];
      end else begin
        bad_x <= bad; pix_x <= u[PIX_FRAC+11:PIX_FRAC];
      end
    end
  end

  logic behind;
  assign behind = cam[2] <= (CAM_W'(MIN_DEPTH_MM) <<< (ROT_FRAC + 8));

  assign sts.range_ok = rvalid;
  assign sts.behind   = behind;
  assign sts.out_free = !out_valid || out_ready;

  // output register; hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      status    <= '0;
      pixel_x   <= '0;
      pixel_y   <= '0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
      pixel_x   <= '0;
      pixel_y   <= '0;
      if (!rvalid)            status <= ST_INVALID;
      else if (behind)        status <= ST_BEHIND;
      else if (bad_x || bad_y) status <= ST_OUTSIDE;
      else begin
        status  <= ST_INSIDE;
        pixel_x <= pix_x;
        pixel_y <= pix_y;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lidar_point_projection_unit.sv =====
// Top level of the lidar point projection unit.
// Use:
//   Write the seven setup registers on the cfg channel (cfg_index, cfg_data) while
//   the unit is idle; cfg_ready is always high. Feed one range sample per beat on
//   the input channel (range_mm, range_valid, scan_start). Each sample gives one
//   result beat (status, pixel_x, pixel_y).
// Sequence:
//   A valid sample runs the CORDIC steps, the point multiply, the transform rows,
//   the depth check, two divisions (set-up, 62 quotient bits, finish) and the
//   result load, after which out_valid rises. Invalid ranges go from the CORDIC
//   state to the result load; points behind the camera skip the divisions.
//   One sample is in work at a time; in_ready is high only when the unit is idle,
//   so a new sample is taken only after the last result has been loaded.
// Reset:
//   rst clears all setup registers, the beam angle and the output valid.
// Stall:
//   A result waits in the output register until taken; a following result waits
//   in the unit, with in_ready low, until the result register is free.
`default_nettype none
module lidar_point_projection_unit (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [lppu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [lppu_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  [15:0]                        range_mm,
  input  wire                                range_valid,
  input  wire                                scan_start,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [1:0]                         status,
  output logic [11:0]                        pixel_x,
  output logic [11:0]                        pixel_y
);
  import lppu_pkg::*;

  lppu_cmd_t cmd;
  lppu_sts_t sts;

  assign cfg_ready = 1'b1;

  lppu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lppu_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .range_mm    (range_mm),
    .range_valid (range_valid),
    .scan_start  (scan_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y)
  );

endmodule
`default_nettype wire

// ===== rtl/lppu_checker.sv =====
// Port-level checks for the lidar point projection unit, bound to the top level.
`default_nettype none
module lppu_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  status,
  input wire [11:0] pixel_x,
  input wire [11:0] pixel_y
);
  import lppu_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(pixel_x)
                                && $stable(pixel_y))
    else $error("result beat changed while stalled");

  a_drop_pixels: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_INSIDE) |-> pixel_x == 12'd0 && pixel_y == 12'd0)
    else $error("pixels nonzero on a rejected point");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample taken while one is in work");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind lidar_point_projection_unit lppu_checker u_lppu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .pixel_x   (pixel_x),
  .pixel_y   (pixel_y)
);
`default_nettype wire
